FILE: src/cau_pkg.sv
// Shared constants, payload structs and codes for the call auction uncrossing block.
package cau_pkg;

    localparam int MAX_ORDERS = 1024;
    localparam int NUM_CELLS  = 16;
    localparam int AW         = $clog2(MAX_ORDERS);
    localparam int CNT_W      = AW + 1;
    localparam int BASE_W     = CNT_W + 1;
    localparam int PRICE_W    = 32;
    localparam int QTY_W      = 32;
    localparam int VOL_W      = QTY_W + AW;
    localparam int OUT_VOL_W  = 42;
    localparam int WAIT_W     = $clog2(NUM_CELLS + 1);

    typedef struct packed {
        logic               valid;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } t_order;

    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   demand;
        logic [VOL_W-1:0]   supply;
    } t_cand;

    typedef enum logic [1:0] {
        PRESS_NONE = 2'd0,
        PRESS_BUY  = 2'd1,
        PRESS_SELL = 2'd2
    } t_press;

endpackage

FILE: src/cau_cell.sv
// One chain cell: holds a candidate price and accumulates its demand and supply.
module cau_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  cau_pkg::t_cand  i_cand,
    output cau_pkg::t_cand  o_cand,
    input  cau_pkg::t_order i_ord,
    output cau_pkg::t_order o_ord
);
    import cau_pkg::*;

    t_cand  r_cand;
    t_cand  n_cand;
    t_order r_ord;

    always_comb begin
        n_cand = r_cand;
        if (i_shift) begin
            n_cand = i_cand;
        end else if (i_ord.valid && r_cand.valid) begin
            if (i_ord.side) begin
                if (i_ord.price >= r_cand.price) begin
                    n_cand.demand = r_cand.demand + VOL_W'(i_ord.qty);
                end
            end else begin
                if (i_ord.price <= r_cand.price) begin
                    n_cand.supply = r_cand.supply + VOL_W'(i_ord.qty);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
            r_ord  <= '0;
        end else begin
            r_cand <= n_cand;
            r_ord  <= i_ord;
        end
    end

    assign o_cand = r_cand;
    assign o_ord  = r_ord;

endmodule

FILE: src/cau_select.sv
// Ranks the candidates leaving the chain and keeps the best one.
module cau_select (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_take,
    input  cau_pkg::t_cand              i_cand,
    input  logic [cau_pkg::PRICE_W-1:0] i_ref,
    output logic                        o_have,
    output logic [cau_pkg::PRICE_W-1:0] o_price,
    output logic [cau_pkg::VOL_W-1:0]   o_volume
);
    import cau_pkg::*;

    logic               r_s1_valid;
    logic [PRICE_W-1:0] r_s1_price;
    logic [VOL_W-1:0]   r_s1_trade;
    logic [VOL_W-1:0]   r_s1_surplus;
    t_press             r_s1_press;
    logic [PRICE_W-1:0] r_s1_dist;

    logic               r_have;
    logic [PRICE_W-1:0] r_price;
    logic [VOL_W-1:0]   r_trade;
    logic [VOL_W-1:0]   r_surplus;
    t_press             r_press;
    logic [PRICE_W-1:0] r_dist;

    logic [VOL_W-1:0]   w_trade;
    logic [VOL_W-1:0]   w_surplus;
    t_press             w_press;
    logic [PRICE_W-1:0] w_dist;
    logic               w_beats;

    always_comb begin
        if (i_cand.demand > i_cand.supply) begin
            w_trade   = i_cand.supply;
            w_surplus = i_cand.demand - i_cand.supply;
            w_press   = PRESS_BUY;
        end else begin
            w_trade   = i_cand.demand;
            w_surplus = i_cand.supply - i_cand.demand;
            w_press   = (i_cand.supply > i_cand.demand) ? PRESS_SELL : PRESS_NONE;
        end
        w_dist = (i_cand.price > i_ref) ? (i_cand.price - i_ref) : (i_ref - i_cand.price);
    end

    always_comb begin
        if (r_s1_trade != r_trade) begin
            w_beats = r_s1_trade > r_trade;
        end else if (r_s1_surplus != r_surplus) begin
            w_beats = r_s1_surplus < r_surplus;
        end else if (r_s1_press == PRESS_BUY && r_press == PRESS_BUY) begin
            w_beats = r_s1_price > r_price;
        end else if (r_s1_press == PRESS_SELL && r_press == PRESS_SELL) begin
            w_beats = r_s1_price < r_price;
        end else if (r_s1_dist != r_dist) begin
            w_beats = r_s1_dist < r_dist;
        end else begin
            w_beats = r_s1_price > r_price;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_have     <= 1'b0;
        end else begin
            r_s1_valid <= i_take && i_cand.valid && (w_trade != '0);
            if (i_clear) begin
                r_have <= 1'b0;
            end else if (r_s1_valid && (!r_have || w_beats)) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_price   <= i_cand.price;
        r_s1_trade   <= w_trade;
        r_s1_surplus <= w_surplus;
        r_s1_press   <= w_press;
        r_s1_dist    <= w_dist;
        if (r_s1_valid && (!r_have || w_beats)) begin
            r_price   <= r_s1_price;
            r_trade   <= r_s1_trade;
            r_surplus <= r_s1_surplus;
            r_press   <= r_s1_press;
            r_dist    <= r_s1_dist;
        end
    end

    assign o_have   = r_have;
    assign o_price  = r_price;
    assign o_volume = r_trade;

endmodule

FILE: src/call_auction_uncrossing.sv
// Top level of the call auction uncrossing block.
// Orders load one per cycle, while o_in_ready is high in the fill state, into a book memory.
// The beat that carries the last-order flag starts the uncrossing: candidate prices are
// taken from the book in groups of NUM_CELLS (16) into a chain of cells, then the whole
// book streams through the chain so that each cell sums the demand and supply at its
// price; the candidates are ranked as the next group shifts them out. The groups run one
// after another, since the book memory has a single read port.
// A new book may load while the previous result waits on the output.
module call_auction_uncrossing (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_is_buy,
    input  logic [cau_pkg::PRICE_W-1:0] i_limit_price,
    input  logic [cau_pkg::QTY_W-1:0]   i_quantity,
    input  logic                        i_last_order,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_crossed,
    output logic [cau_pkg::PRICE_W-1:0] o_clearing_price,
    output logic [cau_pkg::OUT_VOL_W-1:0] o_matched_volume,
    input  logic                        i_cfg_we,
    input  logic [cau_pkg::PRICE_W-1:0] i_cfg_wdata
);
    import cau_pkg::*;

    typedef enum logic [5:0] {
        S_FILL   = 6'b000001,
        S_SHIFT  = 6'b000010,
        S_STREAM = 6'b000100,
        S_WAIT   = 6'b001000,
        S_FLUSH  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    localparam int WORD_W = 1 + PRICE_W + QTY_W;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [WAIT_W-1:0]   r_wait, n_wait;
    logic                r_iss_shift, n_iss_shift;
    logic                r_iss_cval, n_iss_cval;
    logic                r_iss_ord, n_iss_ord;
    logic [PRICE_W-1:0]  r_ref;
    logic                r_ovalid;
    logic                r_crossed;
    logic [PRICE_W-1:0]  r_oprice;
    logic [OUT_VOL_W-1:0] r_ovol;

    logic [WORD_W-1:0]   r_mem [0:MAX_ORDERS-1];
    logic [WORD_W-1:0]   r_rd_data;
    logic [AW-1:0]       w_rd_addr;
    logic                w_wr_en;
    logic                w_accept;
    logic                w_clear;
    logic                w_load_out;
    logic [BASE_W-1:0]   w_sum;
    logic                w_cval;

    t_cand               w_cand [0:NUM_CELLS];
    t_order              w_ord  [0:NUM_CELLS];

    logic                w_have;
    logic [PRICE_W-1:0]  w_best_price;
    logic [VOL_W-1:0]    w_best_vol;

    assign o_in_ready = (r_state == S_FILL);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_wr_en    = w_accept && (r_count < CNT_W'(MAX_ORDERS));
    assign w_sum      = r_base + BASE_W'(r_idx);
    assign w_cval     = w_sum < BASE_W'(r_count);
    assign w_rd_addr  = (r_state == S_SHIFT) ? w_sum[AW-1:0] : r_idx[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_base      = r_base;
        n_idx       = r_idx;
        n_wait      = r_wait;
        n_iss_shift = 1'b0;
        n_iss_cval  = 1'b0;
        n_iss_ord   = 1'b0;
        w_clear     = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_FILL: begin
                if (w_wr_en) begin
                    n_count = r_count + 1'b1;
                end
                if (w_accept && i_last_order) begin
                    n_state = S_SHIFT;
                    n_base  = '0;
                    n_idx   = '0;
                    w_clear = 1'b1;
                end
            end
            S_SHIFT: begin
                n_iss_shift = 1'b1;
                n_iss_cval  = w_cval;
                n_idx       = r_idx + 1'b1;
                if (r_idx == CNT_W'(NUM_CELLS - 1)) begin
                    n_idx  = '0;
                    n_wait = '0;
                    if (r_base < BASE_W'(r_count)) begin
                        n_state = S_STREAM;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_STREAM: begin
                n_iss_ord = 1'b1;
                n_idx     = r_idx + 1'b1;
                if (r_idx == r_count - 1'b1) begin
                    n_idx   = '0;
                    n_wait  = '0;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_wait = r_wait + 1'b1;
                if (r_wait == WAIT_W'(NUM_CELLS - 1)) begin
                    n_state = S_SHIFT;
                    n_base  = r_base + BASE_W'(NUM_CELLS);
                end
            end
            S_FLUSH: begin
                n_wait = r_wait + 1'b1;
                if (r_wait == WAIT_W'(2)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid) begin
                    w_load_out = 1'b1;
                    n_count    = '0;
                    n_state    = S_FILL;
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_count     <= '0;
            r_base      <= '0;
            r_idx       <= '0;
            r_wait      <= '0;
            r_iss_shift <= 1'b0;
            r_iss_cval  <= 1'b0;
            r_iss_ord   <= 1'b0;
            r_ref       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_base      <= n_base;
            r_idx       <= n_idx;
            r_wait      <= n_wait;
            r_iss_shift <= n_iss_shift;
            r_iss_cval  <= n_iss_cval;
            r_iss_ord   <= n_iss_ord;
            if (i_cfg_we) begin
                r_ref <= i_cfg_wdata;
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_crossed <= w_have;
            r_oprice  <= w_have ? w_best_price : '0;
            r_ovol    <= w_have ? OUT_VOL_W'(w_best_vol) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[AW-1:0]] <= {i_is_buy, i_limit_price, i_quantity};
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_comb begin
        w_cand[0].valid  = r_iss_cval;
        w_cand[0].price  = r_rd_data[QTY_W +: PRICE_W];
        w_cand[0].demand = '0;
        w_cand[0].supply = '0;
        w_ord[0].valid   = r_iss_ord;
        w_ord[0].side    = r_rd_data[WORD_W-1];
        w_ord[0].price   = r_rd_data[QTY_W +: PRICE_W];
        w_ord[0].qty     = r_rd_data[QTY_W-1:0];
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_iss_shift),
            .i_cand  (w_cand[g]),
            .o_cand  (w_cand[g+1]),
            .i_ord   (w_ord[g]),
            .o_ord   (w_ord[g+1])
        );
    end

    cau_select u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_clear),
        .i_take   (r_iss_shift),
        .i_cand   (w_cand[NUM_CELLS]),
        .i_ref    (r_ref),
        .o_have   (w_have),
        .o_price  (w_best_price),
        .o_volume (w_best_vol)
    );

    assign o_out_valid      = r_ovalid;
    assign o_crossed        = r_crossed;
    assign o_clearing_price = r_oprice;
    assign o_matched_volume = r_ovol;

endmodule

FILE: src/cau_check.sv
// Port-level checks for the call auction uncrossing block, bound to the top level.
module cau_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_last_order,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_crossed,
    input logic [cau_pkg::PRICE_W-1:0]   o_clearing_price,
    input logic [cau_pkg::OUT_VOL_W-1:0] o_matched_volume
);
    import cau_pkg::*;

    // A beat that is not taken stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_clearing_price)
            && $stable(o_matched_volume) && $stable(o_crossed))
        else $error("output beat changed while stalled");

    a_no_cross_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_crossed |-> o_clearing_price == '0 && o_matched_volume == '0)
        else $error("no cross but nonzero price or volume");

    a_cross_volume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_crossed |-> o_matched_volume != '0)
        else $error("cross reported with zero volume");

    // The last order of a book starts the computation, so no order is taken next.
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_order |=> !o_in_ready)
        else $error("order taken right after the last order");

endmodule

bind call_auction_uncrossing cau_check u_cau_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_last_order     (i_last_order),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_crossed        (o_crossed),
    .o_clearing_price (o_clearing_price),
    .o_matched_volume (o_matched_volume)
);
